/* src/lrl_pkg.sv */
// ----------------------------------------------------------------------------
// lrl_pkg
// Shared constants, types and helpers of the recency list block.
// ----------------------------------------------------------------------------
package lrl_pkg;

    // pool size and stored value width
    localparam int SLOTS      = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = $clog2(SLOTS);

    // stream field widths
    localparam int SLOT_FIELD_W = 4;
    localparam int ACTION_W     = 3;

    // input tdata layout: slot, value
    localparam int IN_SLOT_LO  = 0;
    localparam int IN_VALUE_LO = SLOT_FIELD_W;
    localparam int IN_BITS     = SLOT_FIELD_W + VALUE_BITS;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout: used_slot, read_value, head_slot, lru_slot, list_empty
    localparam int OUT_USED_LO  = 0;
    localparam int OUT_RV_LO    = SLOT_FIELD_W;
    localparam int OUT_HEAD_LO  = OUT_RV_LO + VALUE_BITS;
    localparam int OUT_LRU_LO   = OUT_HEAD_LO + SLOT_FIELD_W;
    localparam int OUT_EMPTY    = OUT_LRU_LO + SLOT_FIELD_W;
    localparam int OUT_BITS     = OUT_EMPTY + 1;
    localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // status codes
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_IGNORED = 1'b1;

    // which ring direction a link memory holds
    typedef enum logic {
        LINK_NEXT = 1'b0,
        LINK_PREV = 1'b1
    } t_link_dir;

    // read and write request to a link memory
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [SLOT_W-1:0] wr_data;
    } t_link_req;

    // slot field to memory index
    function automatic logic [SLOT_W-1:0] slot_to_idx(input logic [SLOT_FIELD_W-1:0] f);
        logic [8:0] w;
        w = {5'd0, f};
        return w[SLOT_W-1:0];
    endfunction

    // slot field names an existing slot
    function automatic logic slot_in_range(input logic [SLOT_FIELD_W-1:0] f);
        return {5'd0, f} < 9'(SLOTS);
    endfunction

    // memory index to slot field
    function automatic logic [SLOT_FIELD_W-1:0] idx_to_field(input logic [SLOT_W-1:0] idx);
        logic [8:0] w;
        w = 9'(idx);
        return w[SLOT_FIELD_W-1:0];
    endfunction

    // ring link of a slot right after reset
    function automatic logic [SLOT_W-1:0] link_reset(input logic [SLOT_W-1:0] idx,
                                                     input t_link_dir dir);
        logic [SLOT_W-1:0] last;
        last = SLOT_W'(SLOTS - 1);
        if (dir == LINK_NEXT) begin
            return (idx == last) ? '0 : idx + SLOT_W'(1);
        end
        return (idx == '0) ? last : idx - SLOT_W'(1);
    endfunction

endpackage

/* src/lrl_ram.sv */
// ----------------------------------------------------------------------------
// lrl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrl_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/lrl_link_mem.sv */
// ----------------------------------------------------------------------------
// lrl_link_mem
// Ring link memory with per-entry written flags; unwritten entries read as
// the reset ring, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lrl_link_mem
    import lrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_link_dir         i_dir,
    input  t_link_req         i_req,
    output logic [SLOT_W-1:0] o_rd_data
);

    logic [SLOTS-1:0]  r_written;
    logic [SLOT_W-1:0] r_rd_addr;
    logic [SLOT_W-1:0] ram_q;

    lrl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr_en),
        .i_wr_addr (i_req.wr_addr),
        .i_wr_data (i_req.wr_data),
        .i_rd_en   (i_req.rd_en),
        .i_rd_addr (i_req.rd_addr),
        .o_rd_data (ram_q)
    );

    // mark entries that hold a written link
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.wr_en) begin
            r_written[i_req.wr_addr] <= 1'b1;
        end
    end

    // address of the read in flight
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // never-written entries follow the reset ring
    assign o_rd_data = r_written[r_rd_addr] ? ram_q : link_reset(r_rd_addr, i_dir);

endmodule

/* src/lru_recency_list.sv */
// ----------------------------------------------------------------------------
// lru_recency_list
// Recency order over a fixed slot pool, kept as a doubly linked ring.
// ----------------------------------------------------------------------------
// Usage:
//   One command enters on the s_axis channel (tuser = action, tdata = slot,
//   value) and exactly one result leaves on the m_axis channel (tdata = used
//   slot, read value, head, least recent slot, empty flag; tuser = status).
//   Commands are handled one at a time. After the input transfer each command
//   has its first reads issued, then passes S_RD_A; removal of the head adds
//   S_RD_B, and removal from the middle of the ring adds S_RD_B, S_WR_A and
//   S_WR_B. Add, write, read, clear, ignored ops and removal of the tail go
//   straight from S_RD_A to the result load in S_DONE.
//   The longest case is set by the next-link memory, which has one read and
//   one write port: a middle removal reads two links and writes three.
//   Links live in two memories, values in a third, all with a registered
//   read port; slot valid bits and ring pointers are flip-flops.
//   Reset restores the ring at once through per-entry written flags: there
//   is no clearing pass and s_axis_tready is high as soon as reset ends.
//   A result waits in the output register while the receiver stalls; the
//   block meanwhile accepts and works the next command and holds its result
//   until the register frees.
// ----------------------------------------------------------------------------
module lru_recency_list
    import lrl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command input
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // slot, value
    input  logic [ACTION_W-1:0]  i_s_axis_tuser,  // action
    // result output
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // used_slot, read_value, head_slot,
                                                  // lru_slot, list_empty
    output logic [0:0]           o_m_axis_tuser   // status
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD_A = 7'b0000010,
        S_RD_B = 7'b0000100,
        S_WR_A = 7'b0001000,
        S_WR_B = 7'b0010000,
        S_DONE = 7'b0100000,
        S_HOLD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // command registers
    logic [ACTION_W-1:0]     r_act, n_act;
    logic [SLOT_FIELD_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0]       r_idx, n_idx;
    logic                    r_ok, n_ok;
    logic [VALUE_BITS-1:0]   r_value, n_value;

    // links captured from memory
    logic [SLOT_W-1:0] r_q, n_q;     // next of the slot
    logic [SLOT_W-1:0] r_p, n_p;     // prev of the slot
    logic [SLOT_W-1:0] r_fn, n_fn;   // next of the tail

    // list state
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_free, n_free;
    logic [SLOT_W-1:0] r_lru, n_lru;
    logic              r_empty, n_empty;

    // result
    logic [SLOT_FIELD_W-1:0] r_used, n_used;
    logic [VALUE_BITS-1:0]   r_rv, n_rv;
    logic                    r_status, n_status;
    logic                    r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data, n_out_data;
    logic                    r_out_user, n_out_user;

    // memory ports
    t_link_req             next_req, prev_req;
    logic [SLOT_W-1:0]     next_q, prev_q;
    logic                  val_wr_en, val_rd_en;
    logic [SLOT_W-1:0]     val_wr_addr, val_rd_addr;
    logic [VALUE_BITS-1:0] val_wr_data, val_q;

    logic                    s_xfer;
    logic                    live;
    logic [ACTION_W-1:0]     in_action;
    logic [SLOT_FIELD_W-1:0] in_slot;
    logic [VALUE_BITS-1:0]   in_value;

    assign in_action = i_s_axis_tuser;
    assign in_slot   = i_s_axis_tdata[IN_SLOT_LO +: SLOT_FIELD_W];
    assign in_value  = i_s_axis_tdata[IN_VALUE_LO +: VALUE_BITS];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign live            = r_ok && r_valid[r_idx];

    lrl_link_mem u_next (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dir     (LINK_NEXT),
        .i_req     (next_req),
        .o_rd_data (next_q)
    );

    lrl_link_mem u_prev (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dir     (LINK_PREV),
        .i_req     (prev_req),
        .o_rd_data (prev_q)
    );

    lrl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_value (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr_en),
        .i_wr_addr (val_wr_addr),
        .i_wr_data (val_wr_data),
        .i_rd_en   (val_rd_en),
        .i_rd_addr (val_rd_addr),
        .o_rd_data (val_q)
    );

    // sequencer and read-modify-write of the ring
    always_comb begin
        logic [OUT_BITS-1:0] res;

        n_state     = r_state;
        n_act       = r_act;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_value     = r_value;
        n_q         = r_q;
        n_p         = r_p;
        n_fn        = r_fn;
        n_valid     = r_valid;
        n_head      = r_head;
        n_free      = r_free;
        n_lru       = r_lru;
        n_empty     = r_empty;
        n_used      = r_used;
        n_rv        = r_rv;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        next_req    = '0;
        prev_req    = '0;
        val_wr_en   = 1'b0;
        val_wr_addr = r_idx;
        val_wr_data = r_value;
        val_rd_en   = 1'b0;
        val_rd_addr = r_idx;
        res         = '0;

        // output register drains on transfer
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // take the command and start the first reads
                if (s_xfer) begin
                    n_act            = in_action;
                    n_slot           = in_slot;
                    n_idx            = slot_to_idx(in_slot);
                    n_ok             = slot_in_range(in_slot);
                    n_value          = in_value;
                    next_req.rd_en   = 1'b1;
                    next_req.rd_addr = slot_to_idx(in_slot);
                    prev_req.rd_en   = 1'b1;
                    prev_req.rd_addr = (in_action == ACT_ADD) ? r_free
                                                              : slot_to_idx(in_slot);
                    val_rd_en        = 1'b1;
                    val_rd_addr      = slot_to_idx(in_slot);
                    n_state          = S_RD_A;
                end
            end

            S_RD_A: begin
                n_q      = next_q;
                n_p      = prev_q;
                n_used   = r_slot;
                n_rv     = '0;
                n_status = STAT_DONE;
                n_state  = S_DONE;
                unique case (r_act)
                    ACT_ADD: begin
                        // store at the free end, which becomes the head
                        val_wr_en        = 1'b1;
                        val_wr_addr      = r_free;
                        n_valid[r_free]  = 1'b1;
                        n_head           = r_free;
                        n_free           = prev_q;
                        n_used           = idx_to_field(r_free);
                        n_rv             = r_value;
                        if (r_empty) begin
                            n_lru   = r_free;
                            n_empty = 1'b0;
                        end else if (r_free == r_lru) begin
                            n_lru = prev_q;
                        end
                    end
                    ACT_REMOVE: begin
                        if (!live) begin
                            n_status = STAT_IGNORED;
                        end else if (r_idx == r_lru && r_idx == r_head) begin
                            // last occupied slot
                            n_valid[r_idx] = 1'b0;
                            n_empty        = 1'b1;
                            n_lru          = r_free;
                        end else if (r_idx == r_lru) begin
                            // tail just joins the free region
                            n_valid[r_idx] = 1'b0;
                            n_lru          = prev_q;
                        end else begin
                            // head or middle: one more next link needed
                            next_req.rd_en   = 1'b1;
                            next_req.rd_addr = (r_idx == r_head) ? r_free : r_lru;
                            n_state          = S_RD_B;
                        end
                    end
                    ACT_WRITE: begin
                        if (live) begin
                            val_wr_en = 1'b1;
                            n_rv      = r_value;
                        end else begin
                            n_status = STAT_IGNORED;
                        end
                    end
                    ACT_READ: begin
                        if (live) begin
                            n_rv = val_q;
                        end else begin
                            n_status = STAT_IGNORED;
                        end
                    end
                    ACT_CLEAR: begin
                        n_valid = '0;
                        n_lru   = r_free;
                        n_empty = 1'b1;
                    end
                    default: begin
                        // unknown action reports the slot unchanged
                        n_status = STAT_IGNORED;
                        if (live) begin
                            n_rv = val_q;
                        end
                    end
                endcase
            end

            S_RD_B: begin
                n_fn           = next_q;
                n_valid[r_idx] = 1'b0;
                if (r_idx == r_head) begin
                    // head removal rotates the ring by one
                    n_head  = r_q;
                    n_free  = next_q;
                    n_state = S_DONE;
                end else begin
                    // unlink from between its neighbors
                    next_req.wr_en   = 1'b1;
                    next_req.wr_addr = r_p;
                    next_req.wr_data = r_q;
                    prev_req.wr_en   = 1'b1;
                    prev_req.wr_addr = r_q;
                    prev_req.wr_data = r_p;
                    n_state          = S_WR_A;
                end
            end

            S_WR_A: begin
                // slot points to the tail and its old successor
                next_req.wr_en   = 1'b1;
                next_req.wr_addr = r_idx;
                next_req.wr_data = r_fn;
                prev_req.wr_en   = 1'b1;
                prev_req.wr_addr = r_idx;
                prev_req.wr_data = r_lru;
                n_state          = S_WR_B;
            end

            S_WR_B: begin
                // splice in right after the tail
                prev_req.wr_en   = 1'b1;
                prev_req.wr_addr = r_fn;
                prev_req.wr_data = r_idx;
                next_req.wr_en   = 1'b1;
                next_req.wr_addr = r_lru;
                next_req.wr_data = r_idx;
                if (r_lru == r_free) begin
                    n_free = r_idx;
                end
                n_state = S_DONE;
            end

            S_DONE, S_HOLD: begin
                // load the result once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    res[OUT_USED_LO +: SLOT_FIELD_W] = r_used;
                    res[OUT_RV_LO +: VALUE_BITS]     = r_rv;
                    res[OUT_HEAD_LO +: SLOT_FIELD_W] = r_empty ? '0 : idx_to_field(r_head);
                    res[OUT_LRU_LO +: SLOT_FIELD_W]  = r_empty ? '0 : idx_to_field(r_lru);
                    res[OUT_EMPTY]                   = r_empty;
                    n_out_data                       = '0;
                    n_out_data[OUT_BITS-1:0]         = res;
                    n_out_user                       = r_status;
                    n_out_valid                      = 1'b1;
                    n_state                          = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_head      <= '0;
            r_free      <= SLOT_W'(SLOTS - 1);
            r_lru       <= SLOT_W'(SLOTS - 1);
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_head      <= n_head;
            r_free      <= n_free;
            r_lru       <= n_lru;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_ok       <= n_ok;
        r_value    <= n_value;
        r_q        <= n_q;
        r_p        <= n_p;
        r_fn       <= n_fn;
        r_used     <= n_used;
        r_rv       <= n_rv;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;

endmodule

/* src/lrl_checker.sv */
// ----------------------------------------------------------------------------
// lrl_checker
// Port-level checks of the recency list, bound to the top level.
// ----------------------------------------------------------------------------
module lrl_checker
    import lrl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,  // used_slot, read_value, head_slot,
                                                 // lru_slot, list_empty
    input logic [0:0]           o_m_axis_tuser   // status
);

    logic s_xfer;
    logic out_empty;

    assign s_xfer    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_empty = o_m_axis_tdata[OUT_EMPTY];

    // no result survives a reset
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !o_s_axis_tready)
        else $error("command accepted while one is in work");

    // an empty list reports zero pointers and holds no readable value
    a_empty_reports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && out_empty |->
            o_m_axis_tdata[OUT_HEAD_LO +: SLOT_FIELD_W] == '0 &&
            o_m_axis_tdata[OUT_LRU_LO +: SLOT_FIELD_W] == '0 &&
            o_m_axis_tdata[OUT_RV_LO +: VALUE_BITS] == '0)
        else $error("empty list with nonzero pointer or value");

endmodule

bind lru_recency_list lrl_checker u_lrl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* sim/lru_recency_list_tb.sv */
// ----------------------------------------------------------------------------
// lru_recency_list_tb
// Self-checking bench for the recency list: commands go in on the input
// stream, a scoreboard with its own copy of the ring predicts every result
// and compares it field by field with what the output stream delivers.
// ----------------------------------------------------------------------------
module lru_recency_list_tb
    import lrl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // action codes the block does not know
    localparam logic [ACTION_W-1:0] ACT_BAD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_BAD_HI = 3'd7;

    // random commands to issue
    localparam int RANDOM_ITEMS = 1325;
    // receiver hold-off length in cycles
    localparam int HOLD_CYCLES  = 150;

    // one predicted result
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] used;
        logic [VALUE_BITS-1:0]   rdval;
        logic [SLOT_FIELD_W-1:0] head;
        logic [SLOT_FIELD_W-1:0] lru;
        logic                    empty;
        logic                    status;
    } t_result;

    // ring predictor and pending result store
    class lru_scoreboard;
        logic [SLOT_W-1:0]     fwd [SLOTS];
        logic [SLOT_W-1:0]     bwd [SLOTS];
        logic [VALUE_BITS-1:0] data [SLOTS];
        bit                    live [SLOTS];
        logic [SLOT_W-1:0]     head;
        logic [SLOT_W-1:0]     free_end;
        logic [SLOT_W-1:0]     lru;
        bit                    empty;
        t_result               pending [$];
        int                    errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                fwd[i]  = SLOT_W'((i + 1) % SLOTS);
                bwd[i]  = SLOT_W'((i + SLOTS - 1) % SLOTS);
                data[i] = '0;
                live[i] = 1'b0;
            end
            head     = '0;
            free_end = SLOT_W'(SLOTS - 1);
            lru      = SLOT_W'(SLOTS - 1);
            empty    = 1'b1;
            errors   = 0;
        endfunction

        // random occupied slot, returns 0 when the list is empty
        function bit pick_live(output logic [SLOT_FIELD_W-1:0] s);
            int cnt;
            int k;
            cnt = 0;
            s = '0;
            foreach (live[i]) cnt += live[i];
            if (cnt == 0) return 1'b0;
            k = $urandom_range(0, cnt - 1);
            foreach (live[i]) begin
                if (live[i]) begin
                    if (k == 0) begin
                        s = SLOT_FIELD_W'(i);
                        return 1'b1;
                    end
                    k--;
                end
            end
            return 1'b0;
        endfunction

        // update the ring for an accepted command and queue its result
        function void note_command(logic [ACTION_W-1:0] act, logic [SLOT_FIELD_W-1:0] slot,
                                   logic [VALUE_BITS-1:0] v);
            t_result           r;
            logic [SLOT_W-1:0] used;
            logic              st;
            logic [SLOT_W-1:0] s, p, q, f, fn;
            bit                full;
            used = slot;
            st   = STAT_DONE;
            case (act)
                ACT_ADD: begin
                    // full list reuses the least recent slot
                    full = !empty && free_end == lru;
                    s = free_end;
                    data[s] = v;
                    live[s] = 1'b1;
                    head = s;
                    free_end = bwd[s];
                    if (empty) begin
                        lru = s;
                        empty = 1'b0;
                    end else if (full) begin
                        lru = bwd[s];
                    end
                    used = head;
                end
                ACT_REMOVE: begin
                    if (live[slot]) begin
                        s = slot;
                        live[s] = 1'b0;
                        if (s == lru && s == head) begin
                            empty = 1'b1;
                            lru = free_end;
                        end else if (s == lru) begin
                            lru = bwd[s];
                        end else if (s == head) begin
                            head = fwd[s];
                            free_end = fwd[free_end];
                        end else begin
                            // unlink and reinsert right after the least recent slot
                            p = bwd[s];
                            q = fwd[s];
                            f = lru;
                            fwd[p] = q;
                            bwd[q] = p;
                            fn = fwd[f];
                            bwd[s] = f;
                            fwd[s] = fn;
                            bwd[fn] = s;
                            fwd[f] = s;
                            if (f == free_end) free_end = s;
                        end
                    end else begin
                        st = STAT_IGNORED;
                    end
                end
                ACT_WRITE: begin
                    if (live[slot]) data[slot] = v;
                    else st = STAT_IGNORED;
                end
                ACT_READ: begin
                    if (!live[slot]) st = STAT_IGNORED;
                end
                ACT_CLEAR: begin
                    foreach (live[i]) live[i] = 1'b0;
                    lru = free_end;
                    empty = 1'b1;
                end
                default: st = STAT_IGNORED;
            endcase
            r.used   = used;
            r.rdval  = live[used] ? data[used] : '0;
            r.head   = empty ? '0 : head;
            r.lru    = empty ? '0 : lru;
            r.empty  = empty;
            r.status = st;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [VALUE_BITS-1:0] want,
                                    logic [VALUE_BITS-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one output transfer with the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] d, logic st);
            t_result r;
            if (pending.size() == 0) begin
                $error("result arrived with nothing pending: tdata %0h", d);
                errors++;
                return;
            end
            r = pending.pop_front();
            compare_field("used_slot", VALUE_BITS'(r.used),
                          VALUE_BITS'(d[OUT_USED_LO +: SLOT_FIELD_W]));
            compare_field("read_value", r.rdval, d[OUT_RV_LO +: VALUE_BITS]);
            compare_field("head_slot", VALUE_BITS'(r.head),
                          VALUE_BITS'(d[OUT_HEAD_LO +: SLOT_FIELD_W]));
            compare_field("lru_slot", VALUE_BITS'(r.lru),
                          VALUE_BITS'(d[OUT_LRU_LO +: SLOT_FIELD_W]));
            compare_field("list_empty", VALUE_BITS'(r.empty), VALUE_BITS'(d[OUT_EMPTY]));
            compare_field("status", VALUE_BITS'(r.status), VALUE_BITS'(st));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    logic [S_TDATA_W-1:0] cmd_data = '0;     // slot, value
    logic [ACTION_W-1:0]  cmd_action = '0;   // action
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [M_TDATA_W-1:0] res_data;          // used_slot, read_value, head_slot, lru_slot,
                                             // list_empty
    logic [0:0]           res_status;        // status

    lru_scoreboard recency_sb = new();

    int accepted   = 0;
    int burst_left = 0;
    bit tx_eager   = 1'b0;
    int hold_left  = 0;
    int holds_done = 0;
    int rx_mode    = 0;
    int rx_cycle   = 0;

    lru_recency_list DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .i_s_axis_tuser  (cmd_action),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_status)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        #500_000;
        $display("== FAIL ==");
        $finish;
    end

    // result check and receiver stall pattern
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            recency_sb.check_result(res_data, res_status[0]);
        end
        // long hold-off so the block backs up into its input
        if (hold_left == 0 && holds_done < 2 && accepted >= (holds_done == 0 ? 300 : 900)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom_range(0, 1));
                2: res_ready <= (rx_cycle % 3 == 0);
                default: res_ready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    // offer one command, wait for its transfer, then maybe pause
    task automatic send_cmd(logic [ACTION_W-1:0] act, logic [SLOT_FIELD_W-1:0] slot,
                            logic [VALUE_BITS-1:0] v);
        logic [S_TDATA_W-1:0] d;
        int                   gap;
        d = '0;
        d[IN_SLOT_LO +: SLOT_FIELD_W] = slot;
        d[IN_VALUE_LO +: VALUE_BITS]  = v;
        cmd_valid  <= 1'b1;
        cmd_action <= act;
        cmd_data   <= d;
        do @(posedge clk); while (!cmd_ready);
        recency_sb.note_command(act, slot, v);
        accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = (tx_eager || hold_left > 0 || $urandom_range(0, 3) == 0)
                  ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_valid  <= 1'b0;
                cmd_action <= ACTION_W'($urandom);
                cmd_data   <= S_TDATA_W'({$urandom, $urandom});
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // stimulus
    initial begin
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ACTION_W-1:0]     act;
        int                      done_items;
        int                      mode;
        int                      len;
        int                      add_pct;
        int                      r;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, free slots, unknown actions, all removal kinds
        send_cmd(ACT_READ, 4'd0, 32'h0);
        send_cmd(ACT_REMOVE, 4'd15, 32'h0);
        send_cmd(ACT_WRITE, 4'd3, 32'hFFFF_FFFF);
        for (int a = ACT_BAD_LO; a <= ACT_BAD_HI; a++) begin
            send_cmd(ACTION_W'(a), 4'd15, 32'hFFFF_FFFF);
        end
        send_cmd(ACT_CLEAR, 4'd0, 32'h0);
        send_cmd(ACT_ADD, 4'd0, 32'hFFFF_FFFF);
        send_cmd(ACT_ADD, 4'd15, 32'h0);
        send_cmd(ACT_ADD, 4'd0, 32'hA5A5_A5A5);
        send_cmd(ACT_ADD, 4'd0, 32'h5A5A_5A5A);
        send_cmd(ACT_READ, 4'd15, 32'h0);
        send_cmd(ACT_WRITE, 4'd12, 32'hFFFF_FFFF);
        send_cmd(ACT_REMOVE, 4'd14, 32'h0);
        send_cmd(ACT_REMOVE, 4'd12, 32'h0);
        send_cmd(ACT_REMOVE, 4'd15, 32'h0);
        send_cmd(ACT_READ, 4'd14, 32'h0);
        send_cmd(ACT_WRITE, 4'd13, 32'h0);
        send_cmd(ACT_REMOVE, 4'd13, 32'h0);
        send_cmd(ACT_REMOVE, 4'd13, 32'h0);
        send_cmd(ACT_ADD, 4'd0, 32'h0000_0001);
        send_cmd(ACT_ADD, 4'd0, 32'h8000_0000);
        send_cmd(ACT_CLEAR, 4'd0, 32'h0);
        send_cmd(ACT_READ, 4'd0, 32'h0);

        // random episodes: filling, draining and mixed traffic
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 80);
            tx_eager = ($urandom_range(0, 3) == 0);
            case (mode)
                0: add_pct = 75;
                1: add_pct = 30;
                2: add_pct = 45;
                default: add_pct = 90;
            endcase
            for (int i = 0; i < len && done_items < RANDOM_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < add_pct) begin
                    act = ACT_ADD;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45)      act = ACT_REMOVE;
                    else if (r < 60) act = ACT_WRITE;
                    else if (r < 93) act = ACT_READ;
                    else if (r < 96) act = ACT_CLEAR;
                    else             act = ACTION_W'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
                end
                if ($urandom_range(0, 9) == 0 || !recency_sb.pick_live(slot)) begin
                    slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
                end
                send_cmd(act, slot, $urandom);
                done_items++;
            end
        end
        cmd_valid <= 1'b0;

        // drain, then a short tail for stray results
        while (recency_sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (recency_sb.errors == 0 && recency_sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* lru_recency_list.f */
src/lrl_pkg.sv
src/lrl_ram.sv
src/lrl_link_mem.sv
src/lru_recency_list.sv
src/lrl_checker.sv
sim/lru_recency_list_tb.sv
